// File: rtl/core/i2cseq_pkg.sv
package i2cseq_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CHIP_W    = 7;
    localparam int ALEN_W    = 8;
    localparam int LEN_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic READ_BIT = 1'b1;

    typedef enum logic {
        OP_START = 1'b0,
        OP_EVENT = 1'b1
    } t_op;

    // classified item kinds, event flags already resolved by priority
    typedef enum logic [2:0] {
        K_START  = 3'd0,
        K_ARB    = 3'd1,
        K_IO     = 3'd2,
        K_WR     = 3'd3,
        K_RD     = 3'd4,
        K_NOFLAG = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_LOAD_ADDR = 3'd1,
        ACT_SEND_ADDR = 3'd2,
        ACT_SEND_DATA = 3'd3,
        ACT_RESTART   = 3'd4,
        ACT_STORE_ACK = 3'd5,
        ACT_STORE_END = 3'd6,
        ACT_STOP      = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_BUSY  = 3'd1,
        ST_IO    = 3'd2,
        ST_PROTO = 3'd3,
        ST_NOMEM = 3'd4
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [CHIP_W-1:0]  chip;
        logic [ALEN_W-1:0]  addr_bytes;
        logic [LEN_W-1:0]   length;
        logic               read_mode;
        logic [BYTE_W-1:0]  rx_byte;
    } t_cmd;

    typedef struct packed {
        t_action              action;
        logic [BYTE_W-1:0]    address_value;
        logic [INDEX_W-1:0]   buffer_index;
        logic [BYTE_W-1:0]    store_byte;
        logic                 done_res;
        t_status              status;
        logic                 clear_arb_lost;
        logic                 start_fault;
    } t_result;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic full;
    } t_qwr;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_qrd;

endpackage

// File: rtl/core/i2cseq_front.sv
module i2cseq_front (
    input  logic                 i_s_axis_tvalid,
    input  logic [47:0]          i_s_axis_tdata,
    input  logic                 i_s_axis_tuser,
    output logic                 o_s_axis_tready,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output i2cseq_pkg::t_cmd     o_cmd
);

    logic arb_lost, bus_error, rx_nack, write_ready, read_ready;

    assign arb_lost    = i_s_axis_tdata[32];
    assign bus_error   = i_s_axis_tdata[33];
    assign rx_nack     = i_s_axis_tdata[34];
    assign write_ready = i_s_axis_tdata[35];
    assign read_ready  = i_s_axis_tdata[36];

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_cmd.chip        = i_s_axis_tdata[6:0];
        o_cmd.addr_bytes  = i_s_axis_tdata[14:7];
        o_cmd.length      = i_s_axis_tdata[30:15];
        o_cmd.read_mode   = i_s_axis_tdata[31];
        o_cmd.rx_byte     = i_s_axis_tdata[44:37];
        // flag priority: arbitration, error or nack, write, read
        priority if (i_s_axis_tuser == i2cseq_pkg::OP_START) begin
            o_cmd.kind = i2cseq_pkg::K_START;
        end else if (arb_lost) begin
            o_cmd.kind = i2cseq_pkg::K_ARB;
        end else if (bus_error || rx_nack) begin
            o_cmd.kind = i2cseq_pkg::K_IO;
        end else if (write_ready) begin
            o_cmd.kind = i2cseq_pkg::K_WR;
        end else if (read_ready) begin
            o_cmd.kind = i2cseq_pkg::K_RD;
        end else begin
            o_cmd.kind = i2cseq_pkg::K_NOFLAG;
        end
    end

endmodule

// File: rtl/core/i2cseq_queue.sv
module i2cseq_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cseq_pkg::t_qwr     i_wr,
    input  i2cseq_pkg::t_cmd     i_cmd,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output i2cseq_pkg::t_cmd     o_cmd
);

    i2cseq_pkg::t_cmd                  r_mem [i2cseq_pkg::QUEUE_DEPTH];
    logic [i2cseq_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [i2cseq_pkg::QCNT_W-1:0]     r_count;
    logic                              do_push, do_pop;

    assign o_full  = (r_count == i2cseq_pkg::QCNT_W'(i2cseq_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_wr.push && !i_wr.full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/i2cseq_back.sv
module i2cseq_back #(
    parameter int COUNT_WIDTH = i2cseq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cseq_pkg::t_qrd     i_q,
    input  i2cseq_pkg::t_cmd     i_cmd,
    output logic                 o_pop,
    input  logic                 i_res_ready,
    output logic                 o_res_valid,
    output i2cseq_pkg::t_result  o_res
);

    logic                              r_active, n_active;
    logic [i2cseq_pkg::CHIP_W-1:0]     r_chip, n_chip;
    logic [i2cseq_pkg::ALEN_W-1:0]     r_addr_total, n_addr_total;
    logic [COUNT_WIDTH-1:0]            r_data_total, n_data_total;
    logic                              r_is_read, n_is_read;
    logic [i2cseq_pkg::ALEN_W-1:0]     r_addr_sent, n_addr_sent;
    logic [COUNT_WIDTH-1:0]            r_data_done, n_data_done;
    logic [COUNT_WIDTH-1:0]            done_inc;
    logic                              r_valid;
    i2cseq_pkg::t_result               r_res, n_res;

    assign o_pop       = i_q.valid && (!r_valid || i_res_ready);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;
    assign done_inc    = r_data_done + 1'b1;

    always_comb begin
        n_active     = r_active;
        n_chip       = r_chip;
        n_addr_total = r_addr_total;
        n_data_total = r_data_total;
        n_is_read    = r_is_read;
        n_addr_sent  = r_addr_sent;
        n_data_done  = r_data_done;
        n_res        = '{action: i2cseq_pkg::ACT_NONE, status: i2cseq_pkg::ST_OK,
                         default: '0};
        if (i_cmd.kind == i2cseq_pkg::K_START) begin
            if (r_active) begin
                n_res.start_fault = 1'b1;
            end else begin
                n_chip       = i_cmd.chip;
                n_addr_total = i_cmd.addr_bytes;
                n_data_total = i_cmd.length[COUNT_WIDTH-1:0];
                n_is_read    = i_cmd.read_mode;
                n_addr_sent  = '0;
                n_data_done  = '0;
                n_active     = 1'b1;
                n_res.action = i2cseq_pkg::ACT_LOAD_ADDR;
                n_res.address_value = {i_cmd.chip,
                    (i_cmd.addr_bytes == '0) && i_cmd.read_mode};
            end
        end else if (r_active) begin
            unique case (i_cmd.kind)
                i2cseq_pkg::K_ARB: begin
                    n_res.action         = i2cseq_pkg::ACT_STOP;
                    n_res.clear_arb_lost = 1'b1;
                    n_res.done_res       = 1'b1;
                    n_res.status         = i2cseq_pkg::ST_BUSY;
                    n_active             = 1'b0;
                end
                i2cseq_pkg::K_IO: begin
                    n_res.action   = i2cseq_pkg::ACT_STOP;
                    n_res.done_res = 1'b1;
                    n_res.status   = i2cseq_pkg::ST_IO;
                    n_active       = 1'b0;
                end
                i2cseq_pkg::K_WR: begin
                    priority if (r_addr_sent < r_addr_total) begin
                        n_res.action       = i2cseq_pkg::ACT_SEND_ADDR;
                        n_res.buffer_index = i2cseq_pkg::INDEX_W'(r_addr_sent);
                        n_addr_sent        = r_addr_sent + 1'b1;
                    end else if (r_data_done < r_data_total) begin
                        if (r_is_read) begin
                            n_res.action        = i2cseq_pkg::ACT_RESTART;
                            n_res.address_value = {r_chip, i2cseq_pkg::READ_BIT};
                        end else begin
                            n_res.action       = i2cseq_pkg::ACT_SEND_DATA;
                            n_res.buffer_index = i2cseq_pkg::INDEX_W'(r_data_done);
                            n_data_done        = done_inc;
                        end
                    end else begin
                        n_res.action   = i2cseq_pkg::ACT_STOP;
                        n_res.done_res = 1'b1;
                        n_res.status   = i2cseq_pkg::ST_OK;
                        n_active       = 1'b0;
                    end
                end
                i2cseq_pkg::K_RD: begin
                    if (r_data_done < r_data_total) begin
                        n_res.buffer_index = i2cseq_pkg::INDEX_W'(r_data_done);
                        n_res.store_byte   = i_cmd.rx_byte;
                        n_data_done        = done_inc;
                        if (done_inc < r_data_total) begin
                            n_res.action = i2cseq_pkg::ACT_STORE_ACK;
                        end else begin
                            n_res.action   = i2cseq_pkg::ACT_STORE_END;
                            n_res.done_res = 1'b1;
                            n_res.status   = i2cseq_pkg::ST_OK;
                            n_active       = 1'b0;
                        end
                    end else begin
                        n_res.action   = i2cseq_pkg::ACT_STOP;
                        n_res.done_res = 1'b1;
                        n_res.status   = i2cseq_pkg::ST_NOMEM;
                        n_active       = 1'b0;
                    end
                end
                i2cseq_pkg::K_NOFLAG: begin
                    n_res.done_res = 1'b1;
                    n_res.status   = i2cseq_pkg::ST_PROTO;
                    n_active       = 1'b0;
                end
                default: begin
                    n_res.action = i2cseq_pkg::ACT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_chip       <= '0;
            r_addr_total <= '0;
            r_data_total <= '0;
            r_is_read    <= 1'b0;
            r_addr_sent  <= '0;
            r_data_done  <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_q.pop) begin
                r_active     <= n_active;
                r_chip       <= n_chip;
                r_addr_total <= n_addr_total;
                r_data_total <= n_data_total;
                r_is_read    <= n_is_read;
                r_addr_sent  <= n_addr_sent;
                r_data_done  <= n_data_done;
                r_valid      <= 1'b1;
            end else if (i_res_ready) begin
                r_valid      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q.pop) begin
            r_res <= n_res;
        end
    end

endmodule

// File: rtl/core/i2c_master_transaction_sequencer_unit.sv
// transaction sequencer above a byte-level i2c master. every input beat
// (a start request or a bus event from the byte master) produces exactly
// one result beat carrying the next bus command, the buffer index to use
// and, when the transfer ends, a completion status. a start while a
// transfer is running is refused with start_fault set. the front end
// classifies each beat by event priority (arbitration lost, bus error or
// nack, write done, byte received) into a four-entry queue; the back end
// holds the transfer counters and does one state update per cycle into an
// output register, unless a result held off by the output side blocks it.
// one beat is accepted per cycle, sustained while the output side accepts;
// a result passes the queue write, then the back end's result register. the
// input stalls only when the queue is full while the output side is held off.
module i2c_master_transaction_sequencer_unit #(
    parameter int COUNT_WIDTH = i2cseq_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request and event stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // chip[6:0], addr_bytes[14:7], length[30:15], read_mode[31],
    // arb_lost[32], bus_error[33], rx_nack[34], write_ready[35],
    // read_ready[36], rx_byte[44:37], zero[47:45]
    input  logic [47:0] i_s_axis_tdata,
    // op[0]: 0 start, 1 bus event
    input  logic        i_s_axis_tuser,
    // command stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // address_value[7:0], buffer_index[23:8], store_byte[31:24],
    // done_res[32], status[35:33], clear_arb_lost[36], start_fault[37],
    // zero[39:38]
    output logic [39:0] o_m_axis_tdata,
    // action[2:0]
    output logic [2:0]  o_m_axis_tuser
);

    i2cseq_pkg::t_cmd     front_cmd, q_cmd;
    i2cseq_pkg::t_qwr     q_wr;
    i2cseq_pkg::t_qrd     q_rd;
    i2cseq_pkg::t_result  res;
    logic                 q_push, q_full, q_valid, q_pop;

    assign q_wr.push  = q_push;
    assign q_wr.full  = q_full;
    assign q_rd.valid = q_valid;
    assign q_rd.pop   = q_pop;

    // front end: accept and classify beats
    i2cseq_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_s_axis_tready (o_s_axis_tready),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_cmd           (front_cmd)
    );

    // decoupling queue
    i2cseq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back end: transfer state and result register
    i2cseq_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_rd),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .i_res_ready (i_m_axis_tready),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res)
    );

    // pack the result beat, address_value in the lowest bits
    assign o_m_axis_tdata = {2'b00, res.start_fault, res.clear_arb_lost, res.status,
                             res.done_res, res.store_byte, res.buffer_index,
                             res.address_value};
    assign o_m_axis_tuser = res.action;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import i2cseq_pkg::*;

    // stimulus volume and run limits
    localparam int ITEMS       = 1950;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE      = 8;
    localparam int MAX_SHOWN   = 40;

    // event flag masks, same order as tdata bits 32 to 36
    localparam logic [4:0] FL_NONE = 5'b00000;
    localparam logic [4:0] FL_ARB  = 5'b00001;
    localparam logic [4:0] FL_BUS  = 5'b00010;
    localparam logic [4:0] FL_NACK = 5'b00100;
    localparam logic [4:0] FL_WR   = 5'b01000;
    localparam logic [4:0] FL_RD   = 5'b10000;

    // one input beat before packing
    typedef struct packed {
        t_op         op;
        logic [6:0]  chip;
        logic [7:0]  addr_bytes;
        logic [15:0] length;
        logic        read_mode;
        logic [4:0]  flags;
        logic [7:0]  rx_byte;
    } t_bus_item;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    // chip, addr_bytes, length, read_mode, flags, rx_byte from bit 0 up
    logic [47:0] s_tdata  = '0;
    // op
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    // address_value, buffer_index, store_byte, done_res, status,
    // clear_arb_lost, start_fault from bit 0 up
    logic [39:0] o_m_axis_tdata;
    // action
    logic [2:0]  o_m_axis_tuser;

    // transfer state mirrored by the predictor
    logic        xfer_on   = 1'b0;
    logic [6:0]  seq_chip  = '0;
    logic [7:0]  seq_alen  = '0;
    logic [15:0] seq_len   = '0;
    logic        seq_rd    = 1'b0;
    logic [7:0]  seq_asent = '0;
    logic [15:0] seq_ddone = '0;

    // commands still owed by the block, oldest first
    t_result   pending_cmds[$];
    t_bus_item plan_q[$];

    // directed table
    t_bus_item dir_item[$];
    t_result   dir_typed[$];
    bit        dir_has_typed[$];

    // idle rates and the long receiver hold-off
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 45;
    bit          hold_req      = 1'b0;
    int unsigned hold_left     = 0;

    // transfer shaping for the random part
    int cut_at;
    int fault_at;
    bit cut_done;

    // bookkeeping
    int unsigned n_errors  = 0;
    int unsigned n_in      = 0;
    int unsigned n_out     = 0;
    int unsigned n_refused = 0;
    int unsigned n_stall   = 0;
    int unsigned ended[0:7];

    i2c_master_transaction_sequencer_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // next bus command for one accepted beat, updates the mirrored state
    function automatic t_result next_command(input t_bus_item it);
        t_result r;
        r = '0;
        if (it.op == OP_START) begin
            if (xfer_on) begin
                // refused, running transfer untouched
                r.start_fault = 1'b1;
            end else begin
                seq_chip  = it.chip;
                seq_alen  = it.addr_bytes;
                seq_len   = it.length;
                seq_rd    = it.read_mode;
                seq_asent = '0;
                seq_ddone = '0;
                xfer_on   = 1'b1;
                r.action  = ACT_LOAD_ADDR;
                // no register address to send: go straight to a read
                r.address_value = {it.chip,
                    ((it.addr_bytes == 8'd0) && it.read_mode) ? READ_BIT : 1'b0};
            end
        end else if (!xfer_on) begin
            // event with no transfer running is dropped, result all zero
        end else if ((it.flags & FL_ARB) != FL_NONE) begin
            r.action         = ACT_STOP;
            r.clear_arb_lost = 1'b1;
            r.done_res       = 1'b1;
            r.status         = ST_BUSY;
        end else if ((it.flags & (FL_BUS | FL_NACK)) != FL_NONE) begin
            r.action   = ACT_STOP;
            r.done_res = 1'b1;
            r.status   = ST_IO;
        end else if ((it.flags & FL_WR) != FL_NONE) begin
            if (seq_asent < seq_alen) begin
                r.action       = ACT_SEND_ADDR;
                r.buffer_index = {8'h00, seq_asent};
                seq_asent      = seq_asent + 8'd1;
            end else if (seq_ddone < seq_len) begin
                if (seq_rd) begin
                    r.action        = ACT_RESTART;
                    r.address_value = {seq_chip, READ_BIT};
                end else begin
                    r.action       = ACT_SEND_DATA;
                    r.buffer_index = seq_ddone;
                    seq_ddone      = seq_ddone + 16'd1;
                end
            end else begin
                r.action   = ACT_STOP;
                r.done_res = 1'b1;
                r.status   = ST_OK;
            end
        end else if ((it.flags & FL_RD) != FL_NONE) begin
            if (seq_ddone < seq_len) begin
                r.buffer_index = seq_ddone;
                r.store_byte   = it.rx_byte;
                seq_ddone      = seq_ddone + 16'd1;
                if (seq_ddone < seq_len) begin
                    r.action = ACT_STORE_ACK;
                end else begin
                    r.action   = ACT_STORE_END;
                    r.done_res = 1'b1;
                    r.status   = ST_OK;
                end
            end else begin
                // byte arrived past the requested length
                r.action   = ACT_STOP;
                r.done_res = 1'b1;
                r.status   = ST_NOMEM;
            end
        end else begin
            // no flag at all: protocol fault, no stop issued
            r.action   = ACT_NONE;
            r.done_res = 1'b1;
            r.status   = ST_PROTO;
        end
        if (r.done_res) xfer_on = 1'b0;
        return r;
    endfunction

    function automatic t_bus_item rand_item();
        t_bus_item it;
        it.op          = t_op'($urandom_range(0, 1));
        it.chip        = 7'($urandom);
        it.addr_bytes  = 8'($urandom);
        it.length      = 16'($urandom);
        it.read_mode   = 1'($urandom);
        it.flags       = 5'($urandom);
        it.rx_byte     = 8'($urandom);
        return it;
    endfunction

    function automatic t_bus_item make_event(input logic [4:0] fl);
        t_bus_item it;
        it       = rand_item();
        it.op    = OP_EVENT;
        it.flags = fl;
        return it;
    endfunction

    // flags that end a transfer abnormally, lower priority bits mixed in
    function automatic logic [4:0] fault_flags();
        logic [4:0] fl;
        case ($urandom_range(0, 3))
            0:       fl = FL_ARB | 5'($urandom);
            1:       fl = FL_BUS | (5'($urandom) & (FL_NACK | FL_WR | FL_RD));
            2:       fl = FL_NACK | (5'($urandom) & (FL_WR | FL_RD));
            default: fl = FL_NONE;
        endcase
        return fl;
    endfunction

    // write done, sometimes with a stray byte-received flag underneath
    function automatic logic [4:0] write_flags();
        return FL_WR | (($urandom_range(0, 3) == 0) ? FL_RD : FL_NONE);
    endfunction

    task automatic add_row(input t_op op, input logic [6:0] chip, input logic [7:0] alen,
                           input logic [15:0] len, input logic rd, input logic [4:0] fl,
                           input logic [7:0] rx, input bit typed, input t_result want);
        t_bus_item it;
        it.op          = op;
        it.chip        = chip;
        it.addr_bytes  = alen;
        it.length      = len;
        it.read_mode   = rd;
        it.flags       = fl;
        it.rx_byte     = rx;
        dir_item.push_back(it);
        dir_has_typed.push_back(typed);
        dir_typed.push_back(want);
    endtask

    // append one beat of a well-formed transfer, with an optional refused
    // start slipped in and an optional abort that ends the sequence
    task automatic emit(input t_bus_item it);
        t_bus_item extra;
        if (cut_done) return;
        if (plan_q.size() == fault_at) begin
            extra    = rand_item();
            extra.op = OP_START;
            plan_q.push_back(extra);
        end
        if (plan_q.size() >= cut_at) begin
            it.flags = fault_flags();
            cut_done = 1'b1;
        end
        plan_q.push_back(it);
    endtask

    task automatic plan_transfer();
        t_bus_item s;
        int n_addr;
        int n_data;
        int n_ev;
        if ($urandom_range(0, 99) < 15) begin
            // noise, closed by an abort so the next transfer starts idle
            repeat ($urandom_range(1, 4)) plan_q.push_back(rand_item());
            plan_q.push_back(make_event(fault_flags()));
            return;
        end
        s      = rand_item();
        s.op   = OP_START;
        n_addr = $urandom_range(0, 3);
        n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
        s.addr_bytes  = 8'(n_addr);
        s.length      = 16'(n_data);
        plan_q.push_back(s);
        n_ev     = n_addr + n_data + 1;
        cut_at   = ($urandom_range(0, 99) < 20) ? $urandom_range(1, n_ev) : n_ev + 2;
        fault_at = ($urandom_range(0, 99) < 10) ? $urandom_range(1, n_ev) : n_ev + 2;
        cut_done = 1'b0;
        repeat (n_addr) emit(make_event(write_flags()));
        if (s.read_mode && n_data == 0) begin
            // empty read ends either cleanly or with a byte past the end
            emit(make_event(($urandom_range(0, 1) != 0) ? FL_WR : FL_RD));
        end else if (s.read_mode) begin
            emit(make_event(write_flags()));
            repeat (n_data) emit(make_event(FL_RD));
        end else begin
            repeat (n_data + 1) emit(make_event(write_flags()));
        end
        // stray event after the end, dropped by the block
        if ($urandom_range(0, 9) == 0) plan_q.push_back(make_event(5'($urandom)));
    endtask

    // present one beat, predict its command once it is taken
    task automatic offer(input t_bus_item it, input bit typed, input t_result want);
        t_result r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.rx_byte, it.flags, it.read_mode,
                     it.length, it.addr_bytes, it.chip};
        s_tuser  <= it.op;
        do @(posedge clk); while (!o_s_axis_tready);
        r = next_command(it);
        // typed rows carry their own answer, state still follows the beat
        if (typed) r = want;
        pending_cmds.push_back(r);
        n_in++;
        if (r.done_res) ended[r.status]++;
        if (r.start_fault) n_refused++;
    endtask

    // sender stays quiet until every owed command has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_cmds.size() != 0);
    endtask

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    // receiver ready, with random stalls and the long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // compare every command beat with the oldest prediction
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            n_out++;
            if (pending_cmds.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("%0t: command beat with none expected, actual action %0h data %0h",
                             $time, o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                want = pending_cmds.pop_front();
                check_field("action", want.action, o_m_axis_tuser);
                check_field("address_value", want.address_value, o_m_axis_tdata[7:0]);
                check_field("buffer_index", want.buffer_index, o_m_axis_tdata[23:8]);
                check_field("store_byte", want.store_byte, o_m_axis_tdata[31:24]);
                check_field("done_res", want.done_res, o_m_axis_tdata[32]);
                check_field("status", want.status, o_m_axis_tdata[35:33]);
                check_field("clear_arb_lost", want.clear_arb_lost, o_m_axis_tdata[36]);
                check_field("start_fault", want.start_fault, o_m_axis_tdata[37]);
            end
        end
        if (s_tvalid && !o_s_axis_tready) n_stall++;
    end

    initial begin
        int phase;
        foreach (ended[k]) ended[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: extremes, every command, every way a transfer ends
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, 5'b11111, 8'ha5, 1'b1,
                {ACT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0});
        add_row(OP_START, 7'h7f, 8'h00, 16'h0000, 1'b1, FL_NONE, 8'h00, 1'b1,
                {ACT_LOAD_ADDR, 8'hff, 16'h0000, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0});
        add_row(OP_START, 7'h00, 8'hff, 16'hffff, 1'b0, FL_NONE, 8'h00, 1'b1,
                {ACT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1});
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_WR, 8'h00, 1'b1,
                {ACT_STOP, 8'h00, 16'h0000, 8'h00, 1'b1, ST_OK, 1'b0, 1'b0});
        add_row(OP_START, 7'h00, 8'hff, 16'hffff, 1'b1, FL_NONE, 8'h00, 1'b1,
                {ACT_LOAD_ADDR, 8'h00, 16'h0000, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0});
        add_row(OP_EVENT, 7'h7f, 8'hff, 16'hffff, 1'b1, FL_WR, 8'hff, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_WR | FL_RD, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, 5'b11111, 8'hff, 1'b1,
                {ACT_STOP, 8'h00, 16'h0000, 8'h00, 1'b1, ST_BUSY, 1'b1, 1'b0});
        add_row(OP_START, 7'h55, 8'h01, 16'h0002, 1'b1, FL_NONE, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_WR, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_WR | FL_RD, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_RD, 8'hff, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_RD, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_RD, 8'h3c, 1'b1,
                {ACT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0});
        add_row(OP_START, 7'h2a, 8'h00, 16'h0000, 1'b1, FL_NONE, 8'h00, 1'b1,
                {ACT_LOAD_ADDR, 8'h55, 16'h0000, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0});
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_RD, 8'h5a, 1'b1,
                {ACT_STOP, 8'h00, 16'h0000, 8'h00, 1'b1, ST_NOMEM, 1'b0, 1'b0});
        add_row(OP_START, 7'h11, 8'h00, 16'h0001, 1'b0, FL_NONE, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_WR, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_NONE, 8'h00, 1'b1,
                {ACT_NONE, 8'h00, 16'h0000, 8'h00, 1'b1, ST_PROTO, 1'b0, 1'b0});
        add_row(OP_START, 7'h12, 8'h02, 16'h0003, 1'b0, FL_NONE, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_BUS | FL_WR, 8'h00, 1'b1,
                {ACT_STOP, 8'h00, 16'h0000, 8'h00, 1'b1, ST_IO, 1'b0, 1'b0});
        add_row(OP_START, 7'h01, 8'h00, 16'hffff, 1'b0, FL_NONE, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_NACK | FL_RD, 8'h00, 1'b1,
                {ACT_STOP, 8'h00, 16'h0000, 8'h00, 1'b1, ST_IO, 1'b0, 1'b0});
        add_row(OP_START, 7'h33, 8'h00, 16'h0001, 1'b1, FL_NONE, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_WR, 8'h00, 1'b0, '0);
        add_row(OP_EVENT, 7'h00, 8'h00, 16'h0000, 1'b0, FL_RD, 8'hc3, 1'b0, '0);
        for (int i = 0; i < dir_item.size(); i++)
            offer(dir_item[i], dir_has_typed[i], dir_typed[i]);
        drain();

        // random part in three idle regimes
        phase = 0;
        while (n_in < ITEMS) begin
            if (phase == 0 && n_in >= ITEMS / 3) begin
                phase = 1;
                drain();
                send_idle_pct = 45;
                recv_idle_pct = 19;
            end else if (phase == 1 && n_in >= 2 * ITEMS / 3) begin
                phase = 2;
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // receiver goes away while the sender keeps pushing
                hold_req = 1'b1;
            end
            plan_transfer();
            while (plan_q.size() != 0) offer(plan_q.pop_front(), 1'b0, '0);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (pending_cmds.size() != 0) begin
            n_errors++;
            $display("%0t: %0d commands never arrived, expected action %0h, actual none",
                     $time, pending_cmds.size(), pending_cmds[0].action);
        end
        $display("run: %0d beats in, %0d command beats out, %0d starts refused, %0d stall cycles",
                 n_in, n_out, n_refused, n_stall);
        $display("transfers closed: %0d ok, %0d arb lost, %0d io, %0d protocol, %0d no memory",
                 ended[ST_OK], ended[ST_BUSY], ended[ST_IO], ended[ST_PROTO], ended[ST_NOMEM]);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: i2c_master_transaction_sequencer_unit.f
rtl/core/i2cseq_pkg.sv
rtl/core/i2cseq_front.sv
rtl/core/i2cseq_queue.sv
rtl/core/i2cseq_back.sv
rtl/core/i2c_master_transaction_sequencer_unit.sv
tb/sv/testbench.sv
